// ----- rtl/b64e_pkg.sv -----
package b64e_pkg;

  localparam int unsigned JOB_CHARS = 4;

  // Position of a byte inside its three-byte group.
  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;

  localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
  localparam logic [6:0] PLUS_CHAR  = 7'h2B;  // '+'
  localparam logic [6:0] SLASH_CHAR = 7'h2F;  // '/'
  localparam logic [6:0] UPPER_BASE = 7'h41;  // 'A'
  localparam logic [6:0] LOWER_BASE = 7'h47;  // 'a' minus 26
  localparam logic [6:0] DIGIT_BASE = 7'h7C;  // '0' minus 52, modulo 128

  // One classified byte: up to four characters, the index of the last
  // one, and whether that last character ends the message.
  typedef struct packed {
    logic [JOB_CHARS-1:0][6:0] chars;
    logic [1:0]                last_idx;
    logic                      fin;
  } job_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = UPPER_BASE + {1'b0, v};
    end else if (v < 6'd52) begin
      r = LOWER_BASE + {1'b0, v};
    end else if (v < 6'd62) begin
      r = DIGIT_BASE + {1'b0, v};
    end else if (v == 6'd62) begin
      r = PLUS_CHAR;
    end else begin
      r = SLASH_CHAR;
    end
    return r;
  endfunction

endpackage

// ----- rtl/b64e_front.sv -----
module b64e_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_final_byte,
  output logic          push,
  output b64e_pkg::job_t push_job,
  input  logic          q_full
);
  import b64e_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic       take;
  job_t       job;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take;
  assign push_job = job;

  always_comb begin
    job          = '0;
    job.chars[2] = PAD_CHAR;
    job.chars[3] = PAD_CHAR;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    unique case (phase_r)
      PHASE_1: begin
        job.chars[0] = b64_char({left_r[1:0], in_data_byte[7:4]});
        job.chars[1] = b64_char({in_data_byte[3:0], 2'b00});
        job.last_idx = in_final_byte ? 2'd2 : 2'd0;
        job.fin      = in_final_byte;
        phase_nxt    = PHASE_2;
        left_nxt     = in_data_byte[3:0];
      end
      PHASE_2: begin
        job.chars[0] = b64_char({left_r, in_data_byte[7:6]});
        job.chars[1] = b64_char(in_data_byte[5:0]);
        job.last_idx = 2'd1;
        job.fin      = in_final_byte;
        phase_nxt    = PHASE_0;
        left_nxt     = 4'd0;
      end
      default: begin
        job.chars[0] = b64_char(in_data_byte[7:2]);
        job.chars[1] = b64_char({in_data_byte[1:0], 4'b0000});
        job.last_idx = in_final_byte ? 2'd3 : 2'd0;
        job.fin      = in_final_byte;
        phase_nxt    = PHASE_1;
        left_nxt     = {2'b00, in_data_byte[1:0]};
      end
    endcase
    if (in_final_byte) begin
      phase_nxt = PHASE_0;
      left_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_0;
      left_r  <= 4'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PHASE_0 || phase_r == PHASE_1 || phase_r == PHASE_2)
    else $error("group phase out of range");
  a_left_phase0: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PHASE_0 |-> left_r == 4'd0)
    else $error("held bits at group start");
  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_final_byte |=> phase_r == PHASE_0)
    else $error("group did not restart after last byte");
`endif

endmodule

// ----- rtl/b64e_fifo.sv -----
module b64e_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b64e_pkg::job_t head_job
);
  import b64e_pkg::*;

  job_t       mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_job   = mem_r[rd_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) == (wr_r != rd_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/b64e_back.sv -----
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  b64e_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           out_final_char
);
  import b64e_pkg::*;

  job_t       cur_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       oval_r;
  logic [6:0] ochar_r;
  logic       ofin_r;
  logic       advance;
  logic       job_done;

  assign advance  = busy_r && (!oval_r || out_ready);
  assign job_done = idx_r == cur_r.last_idx;
  assign pop      = head_valid && (!busy_r || (advance && job_done));

  assign out_valid      = oval_r;
  assign out_char       = ochar_r;
  assign out_final_char = ofin_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_job;
    end
    if (advance) begin
      ochar_r <= cur_r.chars[idx_r];
      ofin_r  <= cur_r.fin && job_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      oval_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (advance && job_done) begin
        busy_r <= 1'b0;
      end else if (advance) begin
        idx_r <= idx_r + 2'd1;
      end
      if (advance) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= cur_r.last_idx)
    else $error("character index past end of job");
  a_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !job_done |=> busy_r && idx_r == $past(idx_r) + 2'd1)
    else $error("job left before its last character");
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !job_done |=> !ofin_r)
    else $error("final flag on inner character");
`endif

endmodule

// ----- rtl/base64_stream_encoder_top.sv -----
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_data_byte[7:0], in_final_byte
// out_      output     out_valid/out_ready  out_char[6:0], out_final_char
//
// Each byte is classified into one to four characters in the cycle it is
// transferred. The back end sends one character per cycle while out_ready
// is high and a job is queued, so the single-character output channel
// sets the throughput. The input accepts a byte whenever the two-entry
// queue has room. Reset (rst_n low, synchronous) empties the queue and the
// output register and starts a new three-byte group. A stalled output fills
// the queue, then drops in_ready.
module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_final_char
);
  import b64e_pkg::*;

  // Front end: tracks the group phase and held bits, and turns each
  // transferred byte into a job holding all of its characters.
  logic push;
  job_t push_job;
  logic q_full;

  // Back end side of the queue.
  logic pop;
  logic head_valid;
  job_t head_job;

  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .push          (push),
    .push_job      (push_job),
    .q_full        (q_full)
  );

  // The queue decouples byte intake from character output.
  b64e_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: walks through a job one character at a time into a
  // registered output stage.
  b64e_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_final_char (out_final_char)
  );

endmodule
